// ===== rtl/kcl_pkg.sv =====
// shared types, key codes and prompt codes for the keypad code lock
package kcl_pkg;

  typedef struct packed {
    logic [1:0] key_row;
    logic [1:0] key_column;
  } kcl_in_t;

  typedef struct packed {
    logic [3:0]  prompt_state;
    logic [2:0]  digits_held;
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic [15:0] servo_pulse;
    logic [15:0] buzzer_level;
    logic [15:0] warn_level;
    logic        alarm_led;
  } kcl_out_t;

  // configuration register indexes
  localparam logic [1:0] CFG_UNLOCK_PULSE = 2'd0;
  localparam logic [1:0] CFG_LOCK_PULSE   = 2'd1;
  localparam logic [1:0] CFG_BUZZER_DUTY  = 2'd2;
  localparam logic [1:0] CFG_WARN_DUTY    = 2'd3;

  localparam logic [15:0] UNLOCK_PULSE_RST = 16'd700;
  localparam logic [15:0] LOCK_PULSE_RST   = 16'd1800;
  localparam logic [15:0] BUZZER_DUTY_RST  = 16'd2500;
  localparam logic [15:0] WARN_DUTY_RST    = 16'd4500;

  // command characters
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_NINE = 8'h39;

  // prompt codes
  localparam logic [3:0] PROMPT_NORMAL    = 4'd0;
  localparam logic [3:0] PROMPT_ALARM     = 4'd3;
  localparam logic [3:0] PROMPT_CHANGE    = 4'd4;
  localparam logic [3:0] PROMPT_CHG_ALARM = 4'd7;
  localparam logic [3:0] PROMPT_NEW_CODE  = 4'd8;

  // 4x4 keypad layout, rows "123A" "456B" "789C" "*0#D"
  function automatic logic [7:0] key_char(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] c;
    unique case ({row, col})
      4'h0: c = "1";
      4'h1: c = "2";
      4'h2: c = "3";
      4'h3: c = "A";
      4'h4: c = "4";
      4'h5: c = "5";
      4'h6: c = "6";
      4'h7: c = "B";
      4'h8: c = "7";
      4'h9: c = "8";
      4'ha: c = "9";
      4'hb: c = "C";
      4'hc: c = "*";
      4'hd: c = "0";
      4'he: c = "#";
      4'hf: c = "D";
      default: c = "0";
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/keypad_code_lock.sv =====
// keypad code lock: key decode, entry buffer, code check and actuator levels
//
// Input channel in_valid/in_ready/in_data carries one key press word (row and
// column of a 4x4 keypad). Output channel out_valid/out_ready/out_data carries
// one result word per key: prompt, digits held, echo, servo, buzzer, warning
// and alarm levels. Every key gives exactly one result word, in order.
// The path is two registers deep: a key is captured in an input register,
// then the key decode, the parallel code compare and the state update run
// combinationally into the result register. out_valid rises once the key
// has moved from the input register into the result register; while
// out_ready stays high, one key per cycle is sustained.
// If the receiver stalls, the result register holds and the input register
// still takes one more key; after that in_ready drops until out_ready rises.
// cfg_we/cfg_addr/cfg_wdata write the servo and duty registers; write only
// while no key is in flight. Reset (rst_n low, synchronous) empties both
// registers, restores the default code and duty values and locks the servo.
module keypad_code_lock #(
  parameter int CODE_LENGTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kcl_pkg::kcl_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kcl_pkg::kcl_out_t  out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);
  import kcl_pkg::*;

  localparam int CntW = $clog2(CODE_LENGTH + 1);

  logic [15:0] unlock_pulse_r, lock_pulse_r, buzzer_duty_r, warn_duty_r;

  logic                        s1_valid_r;
  kcl_in_t                     s1_data_r;
  logic                        out_valid_r;
  kcl_out_t                    out_data_r, out_data_nxt;

  logic [CODE_LENGTH-1:0][7:0] entry_r, entry_nxt;
  logic [CODE_LENGTH-1:0][7:0] code_r, code_nxt;
  logic [CntW-1:0]             count_r, count_nxt;
  logic [3:0]                  prompt_r, prompt_nxt;
  logic                        change_r, change_nxt;
  logic                        unlocked_r, unlocked_nxt;
  logic                        alarm_r, alarm_nxt;
  logic [15:0]                 servo_r, servo_nxt;

  logic                        advance;
  logic [7:0]                  ch;
  logic                        append;
  logic                        match;
  logic [CODE_LENGTH-1:0][7:0] entry_app;
  logic [CntW-1:0]             count_app;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlock_pulse_r <= UNLOCK_PULSE_RST;
      lock_pulse_r   <= LOCK_PULSE_RST;
      buzzer_duty_r  <= BUZZER_DUTY_RST;
      warn_duty_r    <= WARN_DUTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_UNLOCK_PULSE: unlock_pulse_r <= cfg_wdata;
        CFG_LOCK_PULSE:   lock_pulse_r   <= cfg_wdata;
        CFG_BUZZER_DUTY:  buzzer_duty_r  <= cfg_wdata;
        CFG_WARN_DUTY:    warn_duty_r    <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  always_comb begin
    ch        = key_char(s1_data_r.key_row, s1_data_r.key_column);
    append    = count_r < CntW'(CODE_LENGTH);
    count_app = append ? CntW'(count_r + 1'b1) : count_r;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      entry_app[i] = (append && count_r == CntW'(i)) ? ch : entry_r[i];
    end
    match = (entry_app == code_r);

    entry_nxt    = entry_app;
    count_nxt    = count_app;
    code_nxt     = code_r;
    prompt_nxt   = prompt_r;
    change_nxt   = change_r;
    unlocked_nxt = unlocked_r;
    alarm_nxt    = alarm_r;
    servo_nxt    = servo_r;

    priority if (ch == CH_STAR) begin
      if (change_r) begin
        change_nxt = 1'b0;
        prompt_nxt = PROMPT_NORMAL;
      end else if (!match) begin
        prompt_nxt = (prompt_r < PROMPT_ALARM) ? prompt_r + 4'd1 : PROMPT_ALARM;
      end else begin
        prompt_nxt   = PROMPT_NORMAL;
        unlocked_nxt = !unlocked_r;
      end
      entry_nxt = '0;
      count_nxt = '0;
    end else if (ch == CH_HASH) begin
      prompt_nxt = PROMPT_CHANGE;
      change_nxt = 1'b1;
      entry_nxt  = '0;
      count_nxt  = '0;
    end else if (ch == CH_A && change_r) begin
      if (!match) begin
        prompt_nxt = (prompt_r < PROMPT_CHG_ALARM) ? prompt_r + 4'd1 : PROMPT_CHG_ALARM;
      end else begin
        prompt_nxt = PROMPT_NEW_CODE;
      end
      entry_nxt = '0;
      count_nxt = '0;
    end else if (ch == CH_B && prompt_r == PROMPT_NEW_CODE) begin
      prompt_nxt = PROMPT_NORMAL;
      code_nxt   = entry_app;
      change_nxt = 1'b0;
      entry_nxt  = '0;
      count_nxt  = '0;
    end else begin
    end

    // actuators follow the new prompt
    if (prompt_nxt == PROMPT_ALARM || prompt_nxt == PROMPT_CHG_ALARM) begin
      unlocked_nxt = 1'b0;
      alarm_nxt    = 1'b1;
      servo_nxt    = lock_pulse_r;
    end else if (prompt_nxt == PROMPT_NORMAL) begin
      alarm_nxt = 1'b0;
      servo_nxt = unlocked_nxt ? unlock_pulse_r : lock_pulse_r;
    end else if (prompt_nxt == PROMPT_NEW_CODE) begin
      alarm_nxt = 1'b0;
      servo_nxt = lock_pulse_r;
    end else begin
    end

    out_data_nxt.prompt_state = prompt_nxt;
    out_data_nxt.digits_held  = 3'(count_nxt);
    out_data_nxt.echo_valid   = append;
    out_data_nxt.echo_char    = ch;
    out_data_nxt.servo_pulse  = servo_nxt;
    out_data_nxt.buzzer_level = alarm_nxt ? buzzer_duty_r : 16'd0;
    out_data_nxt.warn_level   = alarm_nxt ? warn_duty_r : 16'd0;
    out_data_nxt.alarm_led    = alarm_nxt;
  end

  // handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // lock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r    <= '0;
      count_r    <= '0;
      prompt_r   <= PROMPT_NORMAL;
      change_r   <= 1'b0;
      unlocked_r <= 1'b0;
      alarm_r    <= 1'b0;
      servo_r    <= LOCK_PULSE_RST;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        code_r[i] <= 8'(CH_NINE - 8'(i % 10));
      end
    end else if (advance) begin
      entry_r    <= entry_nxt;
      count_r    <= count_nxt;
      code_r     <= code_nxt;
      prompt_r   <= prompt_nxt;
      change_r   <= change_nxt;
      unlocked_r <= unlocked_nxt;
      alarm_r    <= alarm_nxt;
      servo_r    <= servo_nxt;
    end
  end

endmodule
